[design/i2cmts_pkg.sv]
// Shared types and constants of the I2C master transaction sequencer.
// Used by i2cmts_txbuf, i2cmts_core and the top level; depends on nothing.
package i2cmts_pkg;

    // Depth of the transmit buffer; entry 0 is unused, the register address is sent from its own register.
    localparam int TX_BUFFER_DEPTH = 64;
    localparam int TX_ADDR_W       = $clog2(TX_BUFFER_DEPTH);
    localparam int TX_PTR_W        = $clog2(TX_BUFFER_DEPTH + 1);

    typedef logic [TX_ADDR_W-1:0] t_tx_addr;
    typedef logic [TX_PTR_W-1:0]  t_tx_ptr;

    // Operation codes carried in the func field.
    localparam logic [2:0] FUNC_LOAD     = 3'd0;
    localparam logic [2:0] FUNC_START_WR = 3'd1;
    localparam logic [2:0] FUNC_START_RD = 3'd2;
    localparam logic [2:0] FUNC_EVENT    = 3'd3;
    localparam logic [2:0] FUNC_ERROR    = 3'd4;

    // Bus engine event codes.
    localparam logic [2:0] EV_START_SENT  = 3'd0;
    localparam logic [2:0] EV_TX_MODE     = 3'd1;
    localparam logic [2:0] EV_RX_MODE     = 3'd2;
    localparam logic [2:0] EV_TRANSMIT    = 3'd3;
    localparam logic [2:0] EV_TRANSMITTED = 3'd4;
    localparam logic [2:0] EV_RECEIVED    = 3'd5;

    typedef struct packed {
        logic [2:0] func;
        logic [7:0] device_address;
        logic [7:0] register_address;
        logic [7:0] data_byte;
        logic [7:0] count;
        logic [2:0] event_code;
    } t_in_word;

    typedef struct packed {
        logic       address_valid;
        logic [7:0] address_byte;
        logic       write_valid;
        logic [7:0] write_byte;
        logic       start_request;
        logic       stop_request;
        logic       ack_disable;
        logic       rx_valid;
        logic [7:0] rx_index;
        logic [7:0] rx_byte;
        logic       busy_res;
        logic       rejected;
    } t_out_word;

    // Access request from the sequencing logic to the transmit buffer.
    typedef struct packed {
        logic       we;
        t_tx_addr   waddr;
        logic [7:0] wdata;
        t_tx_addr   raddr;
    } t_buf_ctl;

endpackage

[design/i2cmts_txbuf.sv]
// Transmit data buffer: one write port, one registered read port.
// Depends on i2cmts_pkg.
module i2cmts_txbuf (
    input  logic                i_clk,
    input  i2cmts_pkg::t_buf_ctl i_ctl,
    output logic [7:0]          o_rd_data
);

    logic [7:0] r_mem [i2cmts_pkg::TX_BUFFER_DEPTH];
    logic [7:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_ctl.we) begin
            r_mem[i_ctl.waddr] <= i_ctl.wdata;
        end
        r_rd_data <= r_mem[i_ctl.raddr];
    end

    assign o_rd_data = r_rd_data;

endmodule

[design/i2cmts_core.sv]
// Transfer state and per-word sequencing logic of the I2C sequencer.
// Depends on i2cmts_pkg; drives the transmit buffer through a t_buf_ctl.
module i2cmts_core (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_fire,
    input  i2cmts_pkg::t_in_word  i_word,
    input  logic [7:0]            i_rd_data,
    output i2cmts_pkg::t_out_word o_result,
    output i2cmts_pkg::t_buf_ctl  o_buf_ctl
);

    logic                  r_busy, n_busy;
    logic                  r_read_dir, n_read_dir;
    logic [7:0]            r_target, n_target;
    logic [7:0]            r_reg_addr, n_reg_addr;
    i2cmts_pkg::t_tx_ptr   r_load_ptr, n_load_ptr;
    i2cmts_pkg::t_tx_ptr   r_tx_index, n_tx_index;
    i2cmts_pkg::t_tx_ptr   r_tx_length, n_tx_length;
    logic [7:0]            r_rx_index, n_rx_index;
    logic [7:0]            r_rx_length, n_rx_length;

    i2cmts_pkg::t_out_word res;
    i2cmts_pkg::t_tx_ptr   load_inc;
    i2cmts_pkg::t_tx_ptr   tx_inc;
    i2cmts_pkg::t_tx_ptr   rd_ptr;
    logic                  tx_avail;
    logic [7:0]            tx_byte;
    logic [7:0]            rx_next;
    logic                  load_ok;
    logic                  wr_count_bad;

    assign load_inc     = r_load_ptr + i2cmts_pkg::t_tx_ptr'(1);
    assign tx_inc       = r_tx_index + i2cmts_pkg::t_tx_ptr'(1);
    assign tx_avail     = (r_tx_index < r_tx_length);
    assign tx_byte      = (r_tx_index == '0) ? r_reg_addr : i_rd_data;
    assign rx_next      = r_rx_index + 8'd1;
    assign load_ok      = !r_busy &&
                          (32'(r_load_ptr) < 32'(i2cmts_pkg::TX_BUFFER_DEPTH - 1));
    assign wr_count_bad = (32'(i_word.count) > 32'(i2cmts_pkg::TX_BUFFER_DEPTH - 1));

    always_comb begin
        res         = '0;
        n_busy      = r_busy;
        n_read_dir  = r_read_dir;
        n_target    = r_target;
        n_reg_addr  = r_reg_addr;
        n_load_ptr  = r_load_ptr;
        n_tx_index  = r_tx_index;
        n_tx_length = r_tx_length;
        n_rx_index  = r_rx_index;
        n_rx_length = r_rx_length;
        case (i_word.func)
            i2cmts_pkg::FUNC_LOAD: begin
                if (load_ok) begin
                    n_load_ptr = load_inc;
                end else begin
                    res.rejected = 1'b1;
                end
            end
            i2cmts_pkg::FUNC_START_WR: begin
                if (r_busy || wr_count_bad) begin
                    res.rejected = 1'b1;
                end else begin
                    n_busy            = 1'b1;
                    n_read_dir        = 1'b0;
                    n_target          = i_word.device_address;
                    n_reg_addr        = i_word.register_address;
                    n_tx_index        = '0;
                    n_tx_length       = i2cmts_pkg::t_tx_ptr'(32'(i_word.count) + 32'd1);
                    n_load_ptr        = '0;
                    res.start_request = 1'b1;
                end
            end
            i2cmts_pkg::FUNC_START_RD: begin
                if (r_busy || i_word.count == 8'd0) begin
                    res.rejected = 1'b1;
                end else begin
                    n_busy            = 1'b1;
                    n_read_dir        = 1'b1;
                    n_target          = i_word.device_address;
                    n_reg_addr        = i_word.register_address;
                    n_tx_index        = '0;
                    n_tx_length       = i2cmts_pkg::t_tx_ptr'(1);
                    n_rx_index        = 8'd0;
                    n_rx_length       = i_word.count;
                    res.start_request = 1'b1;
                end
            end
            i2cmts_pkg::FUNC_EVENT: begin
                if (r_busy) begin
                    case (i_word.event_code)
                        i2cmts_pkg::EV_START_SENT: begin
                            // The direction bit is only set after the register
                            // address has gone out, i.e. on the repeated start.
                            res.address_valid = 1'b1;
                            res.address_byte  = {r_target[7:1],
                                                 (r_tx_index != '0) && r_read_dir};
                        end
                        i2cmts_pkg::EV_TX_MODE: begin
                            if (tx_avail) begin
                                res.write_valid = 1'b1;
                                res.write_byte  = tx_byte;
                                n_tx_index      = tx_inc;
                            end
                        end
                        i2cmts_pkg::EV_RX_MODE: begin
                            if (r_rx_length == 8'd1) begin
                                res.ack_disable  = 1'b1;
                                res.stop_request = 1'b1;
                            end
                        end
                        i2cmts_pkg::EV_TRANSMIT: begin
                            if (!r_read_dir && tx_avail) begin
                                res.write_valid = 1'b1;
                                res.write_byte  = tx_byte;
                                n_tx_index      = tx_inc;
                            end
                        end
                        i2cmts_pkg::EV_TRANSMITTED: begin
                            if (r_read_dir) begin
                                res.start_request = 1'b1;
                            end else if (tx_avail) begin
                                res.write_valid = 1'b1;
                                res.write_byte  = tx_byte;
                                n_tx_index      = tx_inc;
                            end else begin
                                res.stop_request = 1'b1;
                                n_busy           = 1'b0;
                            end
                        end
                        i2cmts_pkg::EV_RECEIVED: begin
                            if (r_read_dir) begin
                                res.rx_valid = 1'b1;
                                res.rx_index = r_rx_index;
                                res.rx_byte  = i_word.data_byte;
                                n_rx_index   = rx_next;
                                if (rx_next == r_rx_length - 8'd1) begin
                                    res.ack_disable  = 1'b1;
                                    res.stop_request = 1'b1;
                                end
                                if (rx_next == r_rx_length) begin
                                    n_busy = 1'b0;
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            i2cmts_pkg::FUNC_ERROR: begin
                res.ack_disable  = 1'b1;
                res.stop_request = 1'b1;
                n_busy           = 1'b0;
            end
            default: begin
            end
        endcase
        res.busy_res = n_busy;
    end

    // The read port follows the transmit index so that the next data byte
    // is already registered when the following event needs it.
    assign rd_ptr          = i_fire ? n_tx_index : r_tx_index;
    assign o_buf_ctl.we    = i_fire && (i_word.func == i2cmts_pkg::FUNC_LOAD) && load_ok;
    assign o_buf_ctl.waddr = load_inc[i2cmts_pkg::TX_ADDR_W-1:0];
    assign o_buf_ctl.wdata = i_word.data_byte;
    assign o_buf_ctl.raddr = rd_ptr[i2cmts_pkg::TX_ADDR_W-1:0];
    assign o_result        = res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_read_dir  <= 1'b0;
            r_target    <= 8'd0;
            r_load_ptr  <= '0;
            r_tx_index  <= '0;
            r_tx_length <= '0;
            r_rx_index  <= 8'd0;
            r_rx_length <= 8'd0;
        end else if (i_fire) begin
            r_busy      <= n_busy;
            r_read_dir  <= n_read_dir;
            r_target    <= n_target;
            r_load_ptr  <= n_load_ptr;
            r_tx_index  <= n_tx_index;
            r_tx_length <= n_tx_length;
            r_rx_index  <= n_rx_index;
            r_rx_length <= n_rx_length;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_fire) begin
            r_reg_addr <= n_reg_addr;
        end
    end

`ifndef SYNTH
    a_index_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_tx_index <= r_tx_length))
        else $error("transmit index ran past transmit length");

    a_no_load_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_buf_ctl.we |-> !r_busy)
        else $error("buffer written during a transfer");

    a_error_idles: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && i_word.func == i2cmts_pkg::FUNC_ERROR) |=> !r_busy)
        else $error("error did not end the transfer");

    a_read_one_tx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && r_read_dir) |-> (r_tx_length == i2cmts_pkg::t_tx_ptr'(1)))
        else $error("read transfer with more than the register address to send");
`endif

endmodule

[design/i2c_master_transaction_sequencer_core.sv]
// Top level of the I2C master transaction sequencer: input and result registers.
// Depends on i2cmts_pkg, i2cmts_txbuf and i2cmts_core.

// Usage: the block takes one input word per clock cycle and returns exactly one
// result word for each, in order. A word passes through two registers: the
// input register and the result register, and the sequencing logic
// between them is a single short compare-and-select pass, so a new word can
// enter every cycle as long as result words are taken. While a result word
// waits to be taken, one more word is held in the input register and the
// input then stalls until the result register empties. The
// transmit buffer is a 64 by 8 memory with a registered read port; its read
// address follows the transmit index, so the next data byte is always ready
// for the next bus event. The buffer needs no clearing pass after reset:
// entries that were never loaded are simply never meant to be sent. Software
// loads data bytes first, then starts a write or a read; bus engine events and
// the error input then drive the transfer. Refused loads and starts come back
// with the rejected bit set and leave the transfer state alone.
module i2c_master_transaction_sequencer_core (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  i2cmts_pkg::t_in_word  i_in_word,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output i2cmts_pkg::t_out_word o_out_word
);

    logic                  r_in_valid;
    i2cmts_pkg::t_in_word  r_in_word;
    logic                  r_out_valid;
    i2cmts_pkg::t_out_word r_out_word;

    logic                  advance;
    i2cmts_pkg::t_out_word step_result;
    i2cmts_pkg::t_buf_ctl  buf_ctl;
    logic [7:0]            buf_rd_data;

    // A held word moves to the result register whenever that register is
    // empty or being emptied in the same cycle.
    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;

    i2cmts_core u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_fire    (advance),
        .i_word    (r_in_word),
        .i_rd_data (buf_rd_data),
        .o_result  (step_result),
        .o_buf_ctl (buf_ctl)
    );

    i2cmts_txbuf u_txbuf (
        .i_clk     (i_clk),
        .i_ctl     (buf_ctl),
        .o_rd_data (buf_rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers carry no reset; the valid bits qualify them.
    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_word <= i_in_word;
        end
        if (advance) begin
            r_out_word <= step_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule

[dv/tb_top.sv]
// Self-checking bench for i2c_master_transaction_sequencer_core: directed and random words.
// Depends on i2cmts_pkg and the sequencer RTL; expected bus actions are predicted here.
`timescale 1ns / 100ps

module tb_top;
    import i2cmts_pkg::*;

    // The limit leaves a wide margin above the slowest correct run, even with
    // heavy idling on both sides.
    localparam int CYCLE_LIMIT = 400000;
    // Useful words sent in each random phase. Four phases come to at least 1360.
    localparam int PHASE_WORDS = 340;

    logic      i_clk      = 1'b0;
    logic      i_rst_n    = 1'b0;
    logic      i_in_valid = 1'b0;
    t_in_word  i_in_word  = '0;
    logic      i_out_ready = 1'b0;
    logic      o_in_ready;
    logic      o_out_valid;
    t_out_word o_out_word;

    i2c_master_transaction_sequencer_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_word  (o_out_word)
    );

    // 12 ns clock period.
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predicted sequencer state. It is updated once for every accepted
    // input word, in acceptance order.
    // ------------------------------------------------------------------
    logic       seq_busy;
    logic       rd_dir;
    logic [7:0] tgt_addr;
    logic [7:0] tx_mem [0:TX_BUFFER_DEPTH-1];
    logic [6:0] load_ptr;
    logic [6:0] tx_pos;
    logic [6:0] tx_len;
    logic [7:0] rx_pos;
    logic [7:0] rx_len;
    // Highest buffer entry ever loaded. Loads always fill upward from entry 1,
    // so entries 1 through loaded_top are all known. A write start is kept
    // within that range, so the bench never asks the block to send a buffer
    // entry that was never written.
    logic [6:0] loaded_top;

    t_out_word   pending_actions[$];
    t_out_word   oldest_action;
    int          bad_words     = 0;
    int          useful_words  = 0;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    int unsigned cycle_count   = 0;

    // Takes the next data byte from the transmit buffer, if one is left.
    function automatic bit pop_tx_byte(inout t_out_word r);
        if (tx_pos < tx_len && tx_pos < TX_BUFFER_DEPTH) begin
            r.write_valid = 1'b1;
            r.write_byte  = tx_mem[tx_pos];
            tx_pos++;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // Works out the bus action that one input word causes, and advances the
    // predicted state.
    function automatic t_out_word next_bus_action(t_in_word w);
        t_out_word r;
        r = '0;
        case (w.func)
            FUNC_LOAD: begin
                // A load is dropped while a transfer runs or once the buffer is full.
                if (seq_busy || load_ptr + 1 >= TX_BUFFER_DEPTH) begin
                    r.rejected = 1'b1;
                end else begin
                    tx_mem[load_ptr + 1] = w.data_byte;
                    if (load_ptr + 1 > loaded_top)
                        loaded_top = load_ptr + 1;
                    load_ptr++;
                end
            end
            FUNC_START_WR: begin
                if (seq_busy || w.count > TX_BUFFER_DEPTH - 1) begin
                    r.rejected = 1'b1;
                end else begin
                    seq_busy  = 1'b1;
                    rd_dir    = 1'b0;
                    tgt_addr  = w.device_address;
                    tx_pos    = '0;
                    tx_len    = 7'(w.count + 1);
                    tx_mem[0] = w.register_address;
                    load_ptr  = '0;
                    r.start_request = 1'b1;
                end
            end
            FUNC_START_RD: begin
                // A read leaves the load pointer where it was.
                if (seq_busy || w.count == 8'd0) begin
                    r.rejected = 1'b1;
                end else begin
                    seq_busy  = 1'b1;
                    rd_dir    = 1'b1;
                    tgt_addr  = w.device_address;
                    tx_pos    = '0;
                    tx_len    = 7'd1;
                    tx_mem[0] = w.register_address;
                    rx_pos    = '0;
                    rx_len    = w.count;
                    r.start_request = 1'b1;
                end
            end
            FUNC_EVENT: begin
                // Bus events are ignored while no transfer runs.
                if (seq_busy) begin
                    case (w.event_code)
                        EV_START_SENT: begin
                            // The first address phase is always a write. The read
                            // bit is set only after the register address has gone out.
                            r.address_valid = 1'b1;
                            r.address_byte  = {tgt_addr[7:1],
                                               (tx_pos == 0) ? 1'b0 : rd_dir};
                        end
                        EV_TX_MODE: void'(pop_tx_byte(r));
                        EV_RX_MODE: begin
                            if (rx_len == 8'd1) begin
                                r.ack_disable  = 1'b1;
                                r.stop_request = 1'b1;
                            end
                        end
                        EV_TRANSMIT: begin
                            if (!rd_dir)
                                void'(pop_tx_byte(r));
                        end
                        EV_TRANSMITTED: begin
                            if (rd_dir) begin
                                r.start_request = 1'b1;
                            end else if (!pop_tx_byte(r)) begin
                                r.stop_request = 1'b1;
                                seq_busy = 1'b0;
                            end
                        end
                        EV_RECEIVED: begin
                            if (rd_dir) begin
                                r.rx_valid = 1'b1;
                                r.rx_index = rx_pos;
                                r.rx_byte  = w.data_byte;
                                rx_pos++;
                                // The byte before the last is where NACK and stop are armed.
                                if (rx_pos == rx_len - 8'd1) begin
                                    r.ack_disable  = 1'b1;
                                    r.stop_request = 1'b1;
                                end
                                if (rx_pos == rx_len)
                                    seq_busy = 1'b0;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            FUNC_ERROR: begin
                // An error aborts the transfer, even when the block is idle.
                r.ack_disable  = 1'b1;
                r.stop_request = 1'b1;
                seq_busy = 1'b0;
            end
            default: ;
        endcase
        r.busy_res = seq_busy;
        return r;
    endfunction

    function automatic t_in_word rand_word(logic [2:0] f, logic [2:0] e);
        t_in_word w;
        w.func             = f;
        w.device_address   = 8'($urandom);
        w.register_address = 8'($urandom);
        w.data_byte        = 8'($urandom);
        w.count            = 8'($urandom);
        w.event_code       = e;
        return w;
    endfunction

    // ------------------------------------------------------------------
    // Word transfer. Inputs change only at the falling edge. Each call
    // starts and ends at a falling edge, so valid gets one assignment
    // per step. Valid stays high from one word to the next unless an
    // idle gap is drawn.
    // ------------------------------------------------------------------
    task automatic send_word(input t_in_word w);
        bit useful;
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        // Keep a write start inside the part of the buffer that has been loaded.
        if (w.func == FUNC_START_WR && !seq_busy && w.count < TX_BUFFER_DEPTH &&
            w.count > loaded_top)
            w.count = 8'($urandom_range(loaded_top, 0));
        i_in_valid <= 1'b1;
        i_in_word  <= w;
        do @(posedge i_clk); while (!o_in_ready);
        useful = !(w.func > FUNC_ERROR ||
                   (w.func == FUNC_EVENT && (!seq_busy || w.event_code > EV_RECEIVED)));
        pending_actions.push_back(next_bus_action(w));
        if (useful)
            useful_words++;
        @(negedge i_clk);
    endtask

    task automatic send_op(input logic [2:0] f, input logic [2:0] e);
        send_word(rand_word(f, e));
    endtask

    task automatic send_exact(input logic [2:0] f, input logic [2:0] e,
                              input logic [7:0] dev, input logic [7:0] regaddr,
                              input logic [7:0] dat, input logic [7:0] cnt);
        send_word('{func: f, device_address: dev, register_address: regaddr,
                    data_byte: dat, count: cnt, event_code: e});
    endtask

    // Sender holds off until every predicted action has come back.
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (pending_actions.size() != 0)
            @(negedge i_clk);
    endtask

    // Receiver back-pressure, drawn anew each cycle.
    always @(negedge i_clk)
        i_out_ready <= ($urandom_range(99) >= recv_stall_pct);

    // Result checking: each accepted result word is compared, field by
    // field, with the oldest prediction still waiting.
    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (want !== got) begin
            $display("%0t ns: %s mismatch, expected %h, actual %h", $time, name, want, got);
            bad_words++;
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_actions.size() == 0) begin
                $display("%0t ns: unexpected result word, expected none, actual %h",
                         $time, o_out_word);
                bad_words++;
            end else begin
                oldest_action = pending_actions.pop_front();
                check_field("address_valid", oldest_action.address_valid,
                            o_out_word.address_valid);
                check_field("address_byte", oldest_action.address_byte,
                            o_out_word.address_byte);
                check_field("write_valid", oldest_action.write_valid, o_out_word.write_valid);
                check_field("write_byte", oldest_action.write_byte, o_out_word.write_byte);
                check_field("start_request", oldest_action.start_request,
                            o_out_word.start_request);
                check_field("stop_request", oldest_action.stop_request,
                            o_out_word.stop_request);
                check_field("ack_disable", oldest_action.ack_disable, o_out_word.ack_disable);
                check_field("rx_valid", oldest_action.rx_valid, o_out_word.rx_valid);
                check_field("rx_index", oldest_action.rx_index, o_out_word.rx_index);
                check_field("rx_byte", oldest_action.rx_byte, o_out_word.rx_byte);
                check_field("busy_res", oldest_action.busy_res, o_out_word.busy_res);
                check_field("rejected", oldest_action.rejected, o_out_word.rejected);
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("i2c_master_transaction_sequencer_core verification failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Directed tests
    // ------------------------------------------------------------------

    // Idle behavior and refused starts. An event or an unused function code
    // changes nothing, an error still asks for NACK and stop, a read of zero
    // bytes is refused, and so is a write longer than the buffer.
    task automatic test_idle_and_rejects();
        send_exact(FUNC_EVENT, EV_START_SENT, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        send_exact(3'd7, 3'd7, 8'h00, 8'h00, 8'h00, 8'h00);
        send_exact(FUNC_ERROR, EV_START_SENT, 8'h00, 8'h00, 8'h00, 8'h00);
        send_exact(FUNC_START_RD, EV_START_SENT, 8'hA5, 8'h5A, 8'h00, 8'd0);
        send_exact(FUNC_START_WR, EV_START_SENT, 8'hA5, 8'h5A, 8'h00, 8'd64);
        send_exact(FUNC_START_WR, EV_START_SENT, 8'hA5, 8'h5A, 8'h00, 8'd255);
    endtask

    // A complete register write of two bytes at the byte extremes. Loads and
    // starts sent mid-transfer are refused. A received event and an unknown
    // event are ignored during a write.
    task automatic test_register_write();
        send_exact(FUNC_LOAD, EV_START_SENT, 8'h00, 8'h00, 8'h00, 8'h00);
        send_exact(FUNC_LOAD, EV_START_SENT, 8'h00, 8'h00, 8'hFF, 8'h00);
        send_exact(FUNC_START_WR, EV_START_SENT, 8'hFF, 8'h00, 8'h00, 8'd2);
        send_exact(FUNC_START_RD, EV_START_SENT, 8'h10, 8'h20, 8'h00, 8'd4);
        send_exact(FUNC_LOAD, EV_START_SENT, 8'h00, 8'h00, 8'h77, 8'h00);
        send_exact(FUNC_EVENT, EV_START_SENT, 8'h00, 8'h00, 8'h00, 8'h00);
        send_exact(FUNC_EVENT, EV_TX_MODE, 8'h00, 8'h00, 8'h00, 8'h00);
        send_exact(FUNC_EVENT, EV_TRANSMIT, 8'h00, 8'h00, 8'h00, 8'h00);
        send_exact(FUNC_EVENT, EV_RECEIVED, 8'h00, 8'h00, 8'hC3, 8'h00);
        send_exact(FUNC_EVENT, 3'd6, 8'h00, 8'h00, 8'h00, 8'h00);
        send_exact(FUNC_EVENT, EV_TRANSMITTED, 8'h00, 8'h00, 8'h00, 8'h00);
        send_exact(FUNC_EVENT, EV_TRANSMITTED, 8'h00, 8'h00, 8'h00, 8'h00);
    endtask

    // A one-byte register read. The register address goes out, then a repeated
    // start with the read bit set. NACK and stop come on the receiver-mode
    // event, because only one byte is to come.
    task automatic test_register_read();
        send_exact(FUNC_START_RD, EV_START_SENT, 8'h01, 8'hFF, 8'h00, 8'd1);
        send_exact(FUNC_EVENT, EV_START_SENT, 8'h00, 8'h00, 8'h00, 8'h00);
        send_exact(FUNC_EVENT, EV_TX_MODE, 8'h00, 8'h00, 8'h00, 8'h00);
        send_exact(FUNC_EVENT, EV_TRANSMIT, 8'h00, 8'h00, 8'h00, 8'h00);
        send_exact(FUNC_EVENT, EV_TRANSMITTED, 8'h00, 8'h00, 8'h00, 8'h00);
        send_exact(FUNC_EVENT, EV_START_SENT, 8'h00, 8'h00, 8'h00, 8'h00);
        send_exact(FUNC_EVENT, EV_RX_MODE, 8'h00, 8'h00, 8'h00, 8'h00);
        send_exact(FUNC_EVENT, EV_RECEIVED, 8'h00, 8'h00, 8'hFF, 8'h00);
    endtask

    // ------------------------------------------------------------------
    // Random traffic: mostly well-formed transfers with random content,
    // plus stray words and transfers broken off by an error.
    // ------------------------------------------------------------------
    task automatic maybe_noise();
        if ($urandom_range(99) < 4)
            send_op(3'($urandom), 3'($urandom));
    endtask

    task automatic random_write(input int nload, input int cnt);
        t_in_word w;
        int       steps;
        int       pick;
        repeat (nload) send_op(FUNC_LOAD, 3'($urandom));
        w = rand_word(FUNC_START_WR, 3'($urandom));
        w.count = 8'(cnt);
        send_word(w);
        send_op(FUNC_EVENT, EV_START_SENT);
        maybe_noise();
        send_op(FUNC_EVENT, EV_TX_MODE);
        steps = 0;
        while (seq_busy && steps < 150) begin
            maybe_noise();
            pick = $urandom_range(99);
            if (pick < 40)
                send_op(FUNC_EVENT, EV_TRANSMIT);
            else if (pick < 92)
                send_op(FUNC_EVENT, EV_TRANSMITTED);
            else
                send_op(FUNC_EVENT, EV_TX_MODE);
            steps++;
        end
    endtask

    task automatic random_read(input int cnt);
        t_in_word w;
        int       steps;
        w = rand_word(FUNC_START_RD, 3'($urandom));
        w.count = 8'(cnt);
        send_word(w);
        send_op(FUNC_EVENT, EV_START_SENT);
        send_op(FUNC_EVENT, EV_TX_MODE);
        if ($urandom_range(3) == 0)
            send_op(FUNC_EVENT, EV_TRANSMIT);
        maybe_noise();
        send_op(FUNC_EVENT, EV_TRANSMITTED);
        send_op(FUNC_EVENT, EV_START_SENT);
        send_op(FUNC_EVENT, EV_RX_MODE);
        steps = 0;
        while (seq_busy && steps < 300) begin
            maybe_noise();
            send_op(FUNC_EVENT, EV_RECEIVED);
            steps++;
        end
    endtask

    task automatic random_transfer();
        int pick;
        int n;
        pick = $urandom_range(99);
        if (pick < 38) begin
            n = ($urandom_range(9) == 0) ? $urandom_range(63) : $urandom_range(5);
            random_write(n, ($urandom_range(7) == 0) ? $urandom_range(255) : n);
        end else if (pick < 78) begin
            n = $urandom_range(99);
            if (n < 10)
                random_read(1);
            else if (n < 90)
                random_read($urandom_range(8, 2));
            else if (n < 97)
                random_read($urandom_range(64, 9));
            else
                random_read($urandom_range(255, 65));
        end else if (pick < 82) begin
            // Fill the buffer past full, then write all of it.
            random_write($urandom_range(70, 63), TX_BUFFER_DEPTH - 1);
        end else if (pick < 92) begin
            repeat ($urandom_range(4, 1)) send_op(3'($urandom), 3'($urandom));
        end else begin
            // A transfer broken off by an error after a few events.
            send_op(($urandom_range(1)) ? FUNC_START_RD : FUNC_START_WR, 3'($urandom));
            send_op(FUNC_EVENT, EV_START_SENT);
            repeat ($urandom_range(3)) send_op(FUNC_EVENT, 3'($urandom_range(5)));
            send_op(FUNC_ERROR, 3'($urandom));
        end
    endtask

    // One phase of random traffic at a given idle mix. It ends drained.
    task automatic test_random_traffic(input int send_pct, input int recv_pct,
                                       input bit mid_drain);
        int goal;
        goal = useful_words + PHASE_WORDS;
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        while (useful_words < goal) begin
            random_transfer();
            // Once, the sender waits for every outstanding result before it goes on.
            if (mid_drain && useful_words >= goal - PHASE_WORDS / 2) begin
                wait_drained();
                mid_drain = 1'b0;
            end
        end
        wait_drained();
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin
        seq_busy   = 1'b0;
        rd_dir     = 1'b0;
        tgt_addr   = '0;
        load_ptr   = '0;
        tx_pos     = '0;
        tx_len     = '0;
        rx_pos     = '0;
        rx_len     = '0;
        loaded_top = '0;

        // Synchronous reset, held low at the start of the run.
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_idle_and_rejects();
        test_register_write();
        test_register_read();
        wait_drained();

        test_random_traffic(0, 0, 1'b1);
        test_random_traffic(72, 0, 1'b0);
        test_random_traffic(0, 72, 1'b0);
        test_random_traffic(11, 11, 1'b0);

        // Let anything still on its way out of the block reach the checker.
        repeat (8) @(negedge i_clk);
        if (bad_words == 0 && pending_actions.size() == 0)
            $display("i2c_master_transaction_sequencer_core verification clean");
        else
            $display("i2c_master_transaction_sequencer_core verification failed");
        $finish;
    end

endmodule

[files.f]
design/i2cmts_pkg.sv
design/i2cmts_txbuf.sv
design/i2cmts_core.sv
design/i2c_master_transaction_sequencer_core.sv
dv/tb_top.sv
